>>> src/mbe_pkg.sv
// shared types and constants for the escape-time evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package mbe_pkg;

  // image size defaults
  localparam int unsigned ImgWidthDef  = 1024;
  localparam int unsigned ImgHeightDef = 1024;

  // field widths
  localparam int unsigned PixW    = 10;
  localparam int unsigned IterW   = 16;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 72;

  // fixed-point formats
  localparam int unsigned FracBits = 26;
  localparam logic [38:0] EscapeBound = 39'(64'd4 << FracBits);
  localparam logic [31:0] ColorStep   = 32'h0005_1020;

  // step = (zoom << 4) / size, one quotient chunk a cycle by reciprocal multiplication
  localparam int unsigned DivW     = 36;
  localparam int unsigned StepW    = 33;
  localparam int unsigned ChunkW   = 12;
  localparam int unsigned DivSteps = DivW / ChunkW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [1:0] {
    CfgZoom       = 2'd0,
    CfgCenterReal = 2'd1,
    CfgCenterImag = 2'd2,
    CfgMaxIter    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic load_px;
    logic div_start;
    logic div_step;
    logic map_mul;
    logic map_add;
    logic iter_mul;
    logic iter_upd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_limit;
    logic escaped;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> src/mbe_ctrl.sv
// controller state machine: sequences step division, mapping, iteration and output
// depends on mbe_pkg
`default_nettype none

module mbe_ctrl
  import mbe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  logic      zoom_wr_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StMapMul,
    StMapAdd,
    StIterMul,
    StIterUpd,
    StDone
  } state_e;

  state_e             state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               step_ok_q, step_ok_d;
  logic               out_full_q, out_full_d;
  logic               accept;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_full_q;
  assign accept      = in_valid_i && (state_q == StIdle);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    step_ok_d  = step_ok_q;
    out_full_d = out_full_q;
    cmd_o      = '0;

    if (out_full_q && out_ready_i) begin
      out_full_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load_px = 1'b1;
          if (step_ok_q) begin
            state_d = StMapMul;
          end else begin
            cmd_o.div_start = 1'b1;
            cnt_d           = '0;
            state_d         = StDiv;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          step_ok_d = 1'b1;
          state_d   = StMapMul;
        end
      end
      StMapMul: begin
        cmd_o.map_mul = 1'b1;
        state_d       = StMapAdd;
      end
      StMapAdd: begin
        cmd_o.map_add = 1'b1;
        state_d       = StIterMul;
      end
      StIterMul: begin
        if (stat_i.at_limit) begin
          state_d = StDone;
        end else begin
          cmd_o.iter_mul = 1'b1;
          state_d        = StIterUpd;
        end
      end
      StIterUpd: begin
        if (stat_i.escaped) begin
          state_d = StDone;
        end else begin
          cmd_o.iter_upd = 1'b1;
          state_d        = StIterMul;
        end
      end
      StDone: begin
        // wait for the output register to free up
        if (!out_full_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_full_d     = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // a new zoom invalidates the cached step
    if (zoom_wr_i) begin
      step_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      step_ok_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      step_ok_q  <= step_ok_d;
      out_full_q <= out_full_d;
    end
  end

endmodule

`default_nettype wire

>>> src/mbe_dp.sv
// datapath: step dividers, pixel-to-point mapping, z iteration and output register
// depends on mbe_pkg; driven by mbe_ctrl commands
`default_nettype none

module mbe_dp
  import mbe_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = ImgWidthDef,
  parameter int unsigned IMG_HEIGHT = ImgHeightDef
) (
  input  logic                       clk_i,
  input  ctrl_cmd_t                  cmd_i,
  output dp_stat_t                   stat_o,
  input  logic [InDataW-1:0]         in_data_i,
  input  logic [31:0]                zoom_i,
  input  logic signed [CoordW-1:0]   center_real_i,
  input  logic signed [CoordW-1:0]   center_imag_i,
  input  logic [IterW-1:0]           max_iter_i,
  output logic [OutDataW-1:0]        out_data_o
);

  localparam int unsigned MaxSize = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
  localparam int unsigned RemW    = $clog2(MaxSize);
  localparam int unsigned TW      = RemW + ChunkW;
  localparam int unsigned MW      = TW + 1;
  localparam int unsigned ProdW   = TW + MW;
  localparam int unsigned ShX     = TW + $clog2(IMG_WIDTH);
  localparam int unsigned ShY     = TW + $clog2(IMG_HEIGHT);
  localparam int unsigned DW      = (($clog2(MaxSize) > PixW) ? $clog2(MaxSize) : PixW) + 1;
  localparam int unsigned PW      = DW + StepW + 1;
  // ceil(2^sh / size) gives an exact floor quotient for every dividend below 2^TW
  localparam logic [MW-1:0] RecipX =
    MW'(((64'd1 << ShX) + 64'(IMG_WIDTH) - 64'd1) / 64'(IMG_WIDTH));
  localparam logic [MW-1:0] RecipY =
    MW'(((64'd1 << ShY) + 64'(IMG_HEIGHT) - 64'd1) / 64'(IMG_HEIGHT));
  localparam logic [TW-1:0]        SizeX = TW'(IMG_WIDTH);
  localparam logic [TW-1:0]        SizeY = TW'(IMG_HEIGHT);
  localparam logic signed [DW-1:0] HalfX = DW'(IMG_WIDTH / 2);
  localparam logic signed [DW-1:0] HalfY = DW'(IMG_HEIGHT / 2);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // pixel capture
  logic [PixW-1:0] px_q, py_q;

  // step dividers, dividend shifts out one chunk a cycle, quotient shifts in
  logic [DivW-1:0]   dv_q;
  logic [DivW-1:0]   qx_q, qy_q;
  logic [RemW-1:0]   remx_q, remy_q;
  logic [TW-1:0]     tx, ty;
  logic [ProdW-1:0]  recx, recy;
  logic [ChunkW-1:0] qcx, qcy;
  logic [TW-1:0]     backx, backy;

  // mapping
  logic signed [DW-1:0]    dx, dy;
  logic signed [StepW:0]   stepx_s, stepy_s;
  logic signed [PW-1:0]    mapx_q, mapy_q;
  logic signed [CoordW-1:0] cx_q, cy_q;

  // iteration
  logic signed [CoordW-1:0] zx_q, zy_q;
  logic signed [63:0]       pxx_q, pyy_q, pxy_q;
  logic signed [37:0]       zx2, zy2;
  logic [38:0]              mag;
  logic signed [38:0]       zxy2;
  logic signed [63:0]       nzx_w, nzy_w;
  logic [IterW-1:0]         it_q;

  // output register
  logic [PixW-1:0]   ox_q, oy_q;
  logic [IterW-1:0]  oit_q;
  logic [ColorW-1:0] ocol_q;
  logic [ColorW-1:0] col_d;

  // remainder below size keeps each quotient chunk within ChunkW bits
  assign tx    = {remx_q, dv_q[DivW-1 -: ChunkW]};
  assign ty    = {remy_q, dv_q[DivW-1 -: ChunkW]};
  assign recx  = ProdW'(tx) * ProdW'(RecipX);
  assign recy  = ProdW'(ty) * ProdW'(RecipY);
  assign qcx   = ChunkW'(recx >> ShX);
  assign qcy   = ChunkW'(recy >> ShY);
  assign backx = TW'(qcx) * SizeX;
  assign backy = TW'(qcy) * SizeY;

  assign dx      = $signed({{(DW - PixW){1'b0}}, px_q}) - HalfX;
  assign dy      = $signed({{(DW - PixW){1'b0}}, py_q}) - HalfY;
  assign stepx_s = $signed({1'b0, qx_q[StepW-1:0]});
  assign stepy_s = $signed({1'b0, qy_q[StepW-1:0]});

  // floor truncation is an arithmetic shift
  assign zx2   = 38'(pxx_q >>> FracBits);
  assign zy2   = 38'(pyy_q >>> FracBits);
  assign zxy2  = 39'(pxy_q >>> (FracBits - 1));
  assign mag   = 39'(zx2) + 39'(zy2);
  assign nzx_w = 64'(zx2) - 64'(zy2) + 64'(cx_q);
  assign nzy_w = 64'(zxy2) + 64'(cy_q);

  assign stat_o.escaped  = (mag >= EscapeBound);
  assign stat_o.at_limit = (it_q >= max_iter_i);

  assign col_d = (it_q == max_iter_i) ? '0 : 32'({16'b0, it_q} * ColorStep);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_px) begin
      px_q <= in_data_i[PixW-1:0];
      py_q <= in_data_i[2*PixW-1:PixW];
    end
    if (cmd_i.div_start) begin
      dv_q   <= {zoom_i, 4'b0};
      remx_q <= '0;
      remy_q <= '0;
    end else if (cmd_i.div_step) begin
      dv_q   <= {dv_q[DivW-ChunkW-1:0], {ChunkW{1'b0}}};
      qx_q   <= {qx_q[DivW-ChunkW-1:0], qcx};
      qy_q   <= {qy_q[DivW-ChunkW-1:0], qcy};
      remx_q <= RemW'(tx - backx);
      remy_q <= RemW'(ty - backy);
    end
    if (cmd_i.map_mul) begin
      mapx_q <= dx * stepx_s;
      mapy_q <= dy * stepy_s;
    end
    if (cmd_i.map_add) begin
      cx_q <= sat32(64'(mapx_q) + 64'(center_real_i));
      cy_q <= sat32(64'(mapy_q) + 64'(center_imag_i));
      zx_q <= '0;
      zy_q <= '0;
      it_q <= '0;
    end else if (cmd_i.iter_upd) begin
      zx_q <= sat32(nzx_w);
      zy_q <= sat32(nzy_w);
      it_q <= it_q + 1'b1;
    end
    if (cmd_i.iter_mul) begin
      pxx_q <= zx_q * zx_q;
      pyy_q <= zy_q * zy_q;
      pxy_q <= zx_q * zy_q;
    end
    if (cmd_i.out_load) begin
      ox_q   <= px_q;
      oy_q   <= py_q;
      oit_q  <= it_q;
      ocol_q <= col_d;
    end
  end

  assign out_data_o = {{(OutDataW - 2 * PixW - IterW - ColorW){1'b0}},
                       ocol_q, oit_q, oy_q, ox_q};

endmodule

`default_nettype wire

>>> src/mandelbrot_escape_time.sv
// top level of the escape-time evaluator: config registers, controller and datapath
// depends on mbe_pkg, mbe_ctrl, mbe_dp
//
// Each pixel transaction maps (x, y) to a point c in the view set by zoom and
// center, then runs z = z*z + c until |z|^2 reaches 4.0 or max_iter is hit.
// One pixel is in work at a time; a finished result waits in the output
// register while the next pixel is taken. Each pixel runs the mapping
// multiply and add, then iterations of two steps (three 32x32 multipliers,
// then the escape test and z update), then the load of the output register;
// the next pixel can be taken in the same cycle as its result becomes valid.
// The first pixel after reset or after a zoom write first runs the divider
// that works out the per-axis step, twelve quotient bits a cycle by
// reciprocal multiplication; later pixels reuse it.
`default_nettype none

module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = ImgWidthDef,
  parameter int unsigned IMG_HEIGHT = ImgHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // pixel_x, pixel_y, zero pad
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // out_x, out_y, iterations, color, zero pad
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  logic [31:0]              zoom_q;
  logic signed [CoordW-1:0] center_real_q, center_imag_q;
  logic [IterW-1:0]         max_iter_q;
  logic                     cfg_wr;
  logic                     zoom_wr;
  cfg_idx_e                 cfg_idx;
  ctrl_cmd_t                cmd;
  dp_stat_t                 stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);
  assign zoom_wr     = cfg_wr && (cfg_idx == CfgZoom);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q        <= 32'h0100_0000;
      center_real_q <= '0;
      center_imag_q <= '0;
      max_iter_q    <= 16'd100;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CfgZoom:       zoom_q        <= cfg_data_i;
        CfgCenterReal: center_real_q <= $signed(cfg_data_i);
        CfgCenterImag: center_imag_q <= $signed(cfg_data_i);
        CfgMaxIter:    max_iter_q    <= cfg_data_i[IterW-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .zoom_wr_i   (zoom_wr),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mbe_dp #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_data_i     (s_axis_tdata_i),
    .zoom_i        (zoom_q),
    .center_real_i (center_real_q),
    .center_imag_i (center_imag_q),
    .max_iter_i    (max_iter_q),
    .out_data_o    (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

>>> src/mbe_chk.sv
// port-level checker for the escape-time evaluator, bound to the top level
// depends on mbe_pkg and mandelbrot_escape_time
`default_nettype none

module mbe_chk
  import mbe_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [1:0]        pend_q;
  logic              in_acc, out_acc;
  logic [IterW-1:0]  iter;
  logic [ColorW-1:0] color;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign iter    = m_axis_tdata_o[2*PixW+IterW-1:2*PixW];
  assign color   = m_axis_tdata_o[2*PixW+IterW+ColorW-1:2*PixW+IterW];

  // pixels taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped before it was taken");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (pend_q != 2'd0))
    else $error("result without a pending pixel");

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("second pixel taken while one is in work");

  a_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((color == '0) || (color == 32'({16'b0, iter} * ColorStep))))
    else $error("color does not follow the iteration count");

endmodule

bind mandelbrot_escape_time mbe_chk u_mbe_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
